// ===== hdl/ccpf_pkg.sv =====
// ----------------------------------------------------------------------------
// ccpf_pkg
// shared types, constants and helpers of the coincidence pair filter
// ----------------------------------------------------------------------------
package ccpf_pkg;

	localparam int VALUE_BITS = 8;
	localparam int MAG_W      = VALUE_BITS;
	localparam int NVALS      = 8;
	localparam int KW         = $clog2(NVALS);
	localparam int PROD_W     = 2 * VALUE_BITS;
	localparam int DET_W      = PROD_W + 1;

	typedef logic signed [VALUE_BITS-1:0] val_t;
	typedef logic [MAG_W-1:0] mag_t;

	typedef struct packed {
		logic start_set;
		val_t row_m_x;
		val_t row_m_y;
		val_t row_n_x;
		val_t row_n_y;
	} in_t;

	typedef struct packed {
		val_t earlier_m_x;
		val_t earlier_m_y;
		val_t later_m_x;
		val_t later_m_y;
		val_t earlier_n_x;
		val_t earlier_n_y;
		val_t later_n_x;
		val_t later_n_y;
		logic last_of_run;
		logic store_full;
	} out_t;

	typedef struct packed {
		val_t m_x;
		val_t m_y;
		val_t n_x;
		val_t n_y;
	} row_t;

	typedef struct packed {
		logic done;
		mag_t g;
	} gcd_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DET,
		ST_CHK,
		ST_GCD,
		ST_EMIT,
		ST_FIN
	} state_t;

	function automatic mag_t mag(input val_t v);
		mag_t u;
		u = mag_t'(v);
		return v[VALUE_BITS-1] ? mag_t'(~u + mag_t'(1)) : u;
	endfunction

endpackage

// ===== hdl/ccpf_store.sv =====
// ----------------------------------------------------------------------------
// ccpf_store
// row memory, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module ccpf_store #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  ccpf_pkg::row_t  wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output ccpf_pkg::row_t  rd_data
);

	ccpf_pkg::row_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/ccpf_gcd.sv =====
// ----------------------------------------------------------------------------
// ccpf_gcd
// iterative gcd of eight magnitudes, one subtract, swap or value fetch per cycle
// ----------------------------------------------------------------------------
module ccpf_gcd (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic [ccpf_pkg::NVALS-1:0][ccpf_pkg::MAG_W-1:0] vals,
	output ccpf_pkg::gcd_res_t                         res
);

	logic                    busy_q;
	logic                    done_q;
	logic [ccpf_pkg::KW-1:0] k_q;
	ccpf_pkg::mag_t          a_q;
	ccpf_pkg::mag_t          b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
			end else if (busy_q && b_q == '0 &&
				(a_q == ccpf_pkg::mag_t'(1) || k_q == ccpf_pkg::KW'(ccpf_pkg::NVALS - 1))) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// running gcd folds in one value at a time; stops early once it reaches one
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= '0;
			b_q <= vals[0];
			k_q <= '0;
		end else if (busy_q) begin
			if (b_q == '0) begin
				k_q <= ccpf_pkg::KW'(k_q + 1'b1);
				b_q <= vals[ccpf_pkg::KW'(k_q + 1'b1)];
			end else if (a_q >= b_q) begin
				a_q <= a_q - b_q;
			end else begin
				a_q <= b_q;
				b_q <= a_q;
			end
		end
	end

	assign res.done = done_q;
	assign res.g    = a_q;

endmodule

// ===== hdl/coincidence_pair_filter_top.sv =====
// ----------------------------------------------------------------------------
// coincidence_pair_filter_top
// pairs each arriving lattice row with all stored rows and filters the pairs
// ----------------------------------------------------------------------------
// usage
//   row channel: one transaction per lattice row (row_valid / row_stall / row)
//   start_set in a row empties the store before that row is handled
//   pair channel: one transaction per kept pair, oldest stored row first;
//   last_of_run marks the final pair of a row, store_full is set on all
//   pairs of a row that found the store full (that row is not kept)
//   a row that yields no pair produces no transaction at all
// timing
//   one row at a time; row_stall stays high while a row walks the store
//   per stored row: memory read, products, determinant check, plus the gcd
//   unit when both determinants are positive; per row also accept, end of
//   store and write-back, plus an emit step per kept pair
// reset
//   arst_n clears the row count and all handshake state; no memory sweep
// stall
//   results sit in an output register plus one pending slot (needed to know
//   last_of_run); the walk holds while both are occupied and pair_stall is high
module coincidence_pair_filter_top #(
	parameter int CAPACITY = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           row_valid,
	output logic           row_stall,
	input  ccpf_pkg::in_t  row,
	output logic           pair_valid,
	input  logic           pair_stall,
	output ccpf_pkg::out_t pair
);

	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	ccpf_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     idx_q;
	logic                 full_q;
	ccpf_pkg::row_t       lat_q;
	ccpf_pkg::row_t       ear_q;
	ccpf_pkg::row_t       rd_data;
	logic signed [ccpf_pkg::PROD_W-1:0] pm0_q, pm1_q, pn0_q, pn1_q;
	logic signed [ccpf_pkg::DET_W-1:0]  det_m, det_n;

	ccpf_pkg::out_t       pend_q;
	logic                 pend_valid_q;
	ccpf_pkg::out_t       pend_out;
	ccpf_pkg::out_t       out_q;
	logic                 out_valid_q;
	logic                 out_free;
	ccpf_pkg::out_t       cand;

	ccpf_pkg::gcd_res_t   gres;
	logic [ccpf_pkg::NVALS-1:0][ccpf_pkg::MAG_W-1:0] gvals;

	// control strobes from the state machine, and the determinant check result
	logic accept, rd_en, gcd_start, next_idx, emit_go, fin_go, det_pass;

	assign out_free = !out_valid_q || !pair_stall;
	assign accept   = row_valid && !row_stall;

	assign det_m    = ccpf_pkg::DET_W'(pm0_q) - ccpf_pkg::DET_W'(pm1_q);
	assign det_n    = ccpf_pkg::DET_W'(pn0_q) - ccpf_pkg::DET_W'(pn1_q);
	assign det_pass = !det_m[ccpf_pkg::DET_W-1] && det_m != '0 &&
		!det_n[ccpf_pkg::DET_W-1] && det_n != '0;

	assign gvals[0] = ccpf_pkg::mag(ear_q.m_x);
	assign gvals[1] = ccpf_pkg::mag(ear_q.m_y);
	assign gvals[2] = ccpf_pkg::mag(lat_q.m_x);
	assign gvals[3] = ccpf_pkg::mag(lat_q.m_y);
	assign gvals[4] = ccpf_pkg::mag(ear_q.n_x);
	assign gvals[5] = ccpf_pkg::mag(ear_q.n_y);
	assign gvals[6] = ccpf_pkg::mag(lat_q.n_x);
	assign gvals[7] = ccpf_pkg::mag(lat_q.n_y);

	always_comb begin
		cand.earlier_m_x = ear_q.m_x;
		cand.earlier_m_y = ear_q.m_y;
		cand.later_m_x   = lat_q.m_x;
		cand.later_m_y   = lat_q.m_y;
		cand.earlier_n_x = ear_q.n_x;
		cand.earlier_n_y = ear_q.n_y;
		cand.later_n_x   = lat_q.n_x;
		cand.later_n_y   = lat_q.n_y;
		cand.last_of_run = 1'b0;
		cand.store_full  = full_q;
	end

	// pending pair as it moves to the output, last flag known by now
	always_comb begin
		pend_out             = pend_q;
		pend_out.last_of_run = fin_go;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccpf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		row_stall = 1'b1;
		rd_en     = 1'b0;
		gcd_start = 1'b0;
		next_idx  = 1'b0;
		emit_go   = 1'b0;
		fin_go    = 1'b0;
		case (state_q)
			ccpf_pkg::ST_IDLE: begin
				row_stall = 1'b0;
				if (row_valid) state_d = ccpf_pkg::ST_READ;
			end
			ccpf_pkg::ST_READ: begin
				if (idx_q == cnt_q) begin
					state_d = ccpf_pkg::ST_FIN;
				end else begin
					rd_en   = 1'b1;
					state_d = ccpf_pkg::ST_DET;
				end
			end
			ccpf_pkg::ST_DET: begin
				state_d = ccpf_pkg::ST_CHK;
			end
			ccpf_pkg::ST_CHK: begin
				if (det_pass) begin
					gcd_start = 1'b1;
					state_d   = ccpf_pkg::ST_GCD;
				end else begin
					next_idx = 1'b1;
					state_d  = ccpf_pkg::ST_READ;
				end
			end
			ccpf_pkg::ST_GCD: begin
				if (gres.done) begin
					if (gres.g == ccpf_pkg::mag_t'(1)) begin
						state_d = ccpf_pkg::ST_EMIT;
					end else begin
						next_idx = 1'b1;
						state_d  = ccpf_pkg::ST_READ;
					end
				end
			end
			ccpf_pkg::ST_EMIT: begin
				if (!pend_valid_q || out_free) begin
					emit_go  = 1'b1;
					next_idx = 1'b1;
					state_d  = ccpf_pkg::ST_READ;
				end
			end
			ccpf_pkg::ST_FIN: begin
				if (!pend_valid_q || out_free) begin
					fin_go  = 1'b1;
					state_d = ccpf_pkg::ST_IDLE;
				end
			end
			default: state_d = ccpf_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			idx_q        <= '0;
			full_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				idx_q  <= '0;
				if (row.start_set) begin
					cnt_q  <= '0;
					full_q <= 1'b0;
				end else begin
					full_q <= (cnt_q == CNT_W'(CAPACITY));
				end
			end
			if (next_idx) idx_q <= idx_q + 1'b1;
			if (fin_go && !full_q) cnt_q <= cnt_q + 1'b1;

			if ((emit_go || fin_go) && pend_valid_q) out_valid_q <= 1'b1;
			else if (out_valid_q && !pair_stall) out_valid_q <= 1'b0;

			if (emit_go) pend_valid_q <= 1'b1;
			else if (fin_go) pend_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			lat_q.m_x <= row.row_m_x;
			lat_q.m_y <= row.row_m_y;
			lat_q.n_x <= row.row_n_x;
			lat_q.n_y <= row.row_n_y;
		end
		if (state_q == ccpf_pkg::ST_DET) begin
			ear_q <= rd_data;
			pm0_q <= rd_data.m_x * lat_q.m_y;
			pm1_q <= rd_data.m_y * lat_q.m_x;
			pn0_q <= rd_data.n_x * lat_q.n_y;
			pn1_q <= rd_data.n_y * lat_q.n_x;
		end
		if ((emit_go || fin_go) && pend_valid_q) begin
			out_q <= pend_out;
		end
		if (emit_go) pend_q <= cand;
	end

	assign pair_valid = out_valid_q;
	assign pair       = out_q;

	ccpf_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (fin_go && !full_q),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (lat_q),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	ccpf_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.vals   (gvals),
		.res    (gres)
	);

endmodule

// ===== hdl/ccpf_checker.sv =====
// ----------------------------------------------------------------------------
// ccpf_checker
// port-level checks of the coincidence pair filter
// ----------------------------------------------------------------------------
module ccpf_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           row_valid,
	input logic           row_stall,
	input logic           pair_valid,
	input logic           pair_stall,
	input ccpf_pkg::out_t pair
);

	// stalled result transaction holds
	a_pair_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && pair_stall |=> pair_valid && $stable(pair))
		else $error("pair changed while stalled");

	// one row at a time
	a_row_busy: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && !row_stall |=> row_stall)
		else $error("row taken while previous row busy");

	// a pair that is not last means its row is still being walked
	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && !pair.last_of_run |-> row_stall)
		else $error("open run while input idle");

endmodule

bind coincidence_pair_filter_top ccpf_checker u_ccpf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.row_valid  (row_valid),
	.row_stall  (row_stall),
	.pair_valid (pair_valid),
	.pair_stall (pair_stall),
	.pair       (pair)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the coincidence pair filter: rows are driven through
// a valid/stall channel, kept pairs are predicted in-bench and compared in order
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP          = 32;
	localparam int IDLE_LIMIT   = 200000;
	localparam int RANDOM_ROWS  = 125;

	logic            clk;
	logic            arst_n;
	logic            row_valid;
	logic            row_stall;
	ccpf_pkg::in_t   row;
	logic            pair_valid;
	logic            pair_stall;
	ccpf_pkg::out_t  pair;

	// pending rows for the driver and pairs awaiting the monitor
	ccpf_pkg::in_t   rows_pending[$];
	ccpf_pkg::out_t  pairs_expected[$];

	// predictor state
	ccpf_pkg::row_t  kept_rows[CAP];
	int     kept_count;

	int     mismatches;
	int     rows_sent;
	int     rows_total;
	int     pairs_seen;
	int     full_pairs;
	int     idle_cycles;
	int     drive_gap;
	int     recv_gap;
	int     hold_off;
	bit     hold_done;

	coincidence_pair_filter_top #(.CAPACITY(CAP)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_valid (row_valid),
		.row_stall (row_stall),
		.row       (row),
		.pair_valid(pair_valid),
		.pair_stall(pair_stall),
		.pair      (pair)
	);

	always #5 clk = ~clk;

	function automatic int unsigned abs_val(input ccpf_pkg::val_t v);
		int s;
		s = v;
		return s < 0 ? -s : s;
	endfunction

	function automatic int unsigned gcd_of(input int unsigned a, input int unsigned b);
		int unsigned t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	task automatic add_row(input ccpf_pkg::in_t r);
		rows_pending.insert(rows_pending.size(), r);
	endtask

	// pair the arriving row with every kept row, oldest first
	task automatic predict_pairs(input ccpf_pkg::in_t r);
		ccpf_pkg::row_t  e;
		ccpf_pkg::val_t  v[8];
		int              detm;
		int              detn;
		int unsigned     g;
		bit              full;
		int              n;
		ccpf_pkg::out_t  o;
		if (r.start_set)
			kept_count = 0;
		full = kept_count >= CAP;
		n = 0;
		for (int i = 0; i < kept_count; i++) begin
			e = kept_rows[i];
			detm = int'(e.m_x) * int'(r.row_m_y) - int'(e.m_y) * int'(r.row_m_x);
			detn = int'(e.n_x) * int'(r.row_n_y) - int'(e.n_y) * int'(r.row_n_x);
			if (detm <= 0 || detn <= 0)
				continue;
			v = '{e.m_x, e.m_y, r.row_m_x, r.row_m_y,
				e.n_x, e.n_y, r.row_n_x, r.row_n_y};
			g = 0;
			for (int k = 0; k < 8; k++)
				g = gcd_of(g, abs_val(v[k]));
			if (g != 1)
				continue;
			o = '{v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], 1'b0, full};
			pairs_expected.insert(pairs_expected.size(), o);
			n++;
		end
		// flag the final pair of this row
		if (n > 0)
			pairs_expected[$].last_of_run = 1'b1;
		if (!full) begin
			kept_rows[kept_count] = '{r.row_m_x, r.row_m_y, r.row_n_x, r.row_n_y};
			kept_count++;
		end
	endtask

	function automatic ccpf_pkg::in_t make_row(input bit st, input int a, input int b,
			input int c, input int d);
		ccpf_pkg::in_t r;
		r.start_set = st;
		r.row_m_x = ccpf_pkg::val_t'(a);
		r.row_m_y = ccpf_pkg::val_t'(b);
		r.row_n_x = ccpf_pkg::val_t'(c);
		r.row_n_y = ccpf_pkg::val_t'(d);
		return r;
	endfunction

	// mostly small values so pairs come through, sometimes full range
	function automatic int pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7)
			return $urandom_range(0, 14) - 7;
		return $urandom_range(0, 255) - 128;
	endfunction

	function automatic int short_or_long_gap();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 10)
			return 0;
		if (sel < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver: a new transaction is offered only after the last was accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid <= 1'b0;
			row       <= '0;
			drive_gap <= 0;
		end else begin
			if (row_valid && !row_stall) begin
				predict_pairs(row);
				rows_sent++;
			end
			if (row_valid && row_stall) begin
				// hold payload while stalled
			end else if (drive_gap > 0) begin
				row_valid <= 1'b0;
				drive_gap <= drive_gap - 1;
			end else if (rows_pending.size() > 0) begin
				row_valid <= 1'b1;
				row       <= rows_pending.pop_front();
				drive_gap <= short_or_long_gap();
			end else begin
				row_valid <= 1'b0;
			end
		end
	end

	// monitor: compares each accepted pair against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_stall <= 1'b0;
			recv_gap   <= 0;
			hold_off   <= 0;
			hold_done  <= 1'b0;
		end else begin
			if (pair_valid && !pair_stall) begin
				pairs_seen++;
				if (pair.store_full)
					full_pairs++;
				if (pairs_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected pair transaction %p", pair);
				end else if (pair !== pairs_expected[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pair mismatch: expected %p actual %p",
							pairs_expected[0], pair);
					void'(pairs_expected.pop_front());
				end else begin
					void'(pairs_expected.pop_front());
				end
			end
			// one long hold-off once enough rows have been sent, to back up the block
			if (!hold_done && rows_sent > 60 && hold_off == 0) begin
				hold_off   <= 3000;
				hold_done  <= 1'b1;
				pair_stall <= 1'b1;
			end else if (hold_off > 1) begin
				hold_off   <= hold_off - 1;
				pair_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				hold_off   <= 0;
				recv_gap   <= recv_gap - 1;
				pair_stall <= 1'b1;
			end else begin
				hold_off   <= 0;
				pair_stall <= 1'b0;
				recv_gap   <= short_or_long_gap();
			end
		end
	end

	// watchdog on cycles with no accepted transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (row_valid && !row_stall) || (pair_valid && !pair_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired: %0d rows pending, %0d pairs expected",
				rows_pending.size(), pairs_expected.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int total;
		clk = 1'b0;
		arst_n = 1'b0;
		kept_count = 0;
		mismatches = 0;
		rows_sent = 0;
		pairs_seen = 0;
		full_pairs = 0;
		idle_cycles = 0;

		// directed: extremes, zero rows, coprime and rejected pairs
		add_row(make_row(1, 1, 0, 1, 0));
		add_row(make_row(0, 0, 1, 0, 1));
		add_row(make_row(0, 0, 0, 0, 0));
		add_row(make_row(0, 0, 0, 0, 0));
		add_row(make_row(0, 2, 0, 2, 0));
		add_row(make_row(0, 0, 2, 0, 2));
		add_row(make_row(0, -1, 0, -1, 0));
		add_row(make_row(0, 0, -1, 0, -1));
		add_row(make_row(1, 127, -128, 127, -128));
		add_row(make_row(0, -128, 127, -128, 127));
		add_row(make_row(0, 127, 127, 127, 127));
		add_row(make_row(0, -128, -128, -128, -128));
		add_row(make_row(0, 1, 1, -1, 1));
		add_row(make_row(0, -85, 42, 37, -64));
		// full store: fill well past capacity with mostly small rows
		add_row(make_row(1, 1, 0, 1, 0));
		for (int i = 0; i < CAP + 3; i++)
			add_row(make_row(0, pick_value(), pick_value(),
				pick_value(), pick_value()));
		add_row(make_row(0, 0, 1, 0, 1));
		// restart after a full store
		add_row(make_row(1, 3, -2, 5, 7));
		add_row(make_row(0, 1, 4, -2, 3));

		// random sets of varying length, occasionally overflowing the store
		total = 0;
		while (total < RANDOM_ROWS) begin
			int len;
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(CAP, CAP + 6)
				: $urandom_range(1, 12);
			for (int i = 0; i < len; i++)
				add_row(make_row(i == 0 ? 1'b1 : ($urandom_range(0, 40) == 0),
					pick_value(), pick_value(), pick_value(), pick_value()));
			total += len;
		end
		rows_total = rows_pending.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// last row accepted, then its walk done and every pair drained
		wait (rows_sent == rows_total);
		@(posedge clk);
		wait (pairs_expected.size() == 0 && !row_stall && !pair_valid);
		repeat (20) @(posedge clk);

		$display("covered %0d rows incl. full-store and restart cases, %0d pairs checked",
			rows_sent, pairs_seen);
		$display("%0d pairs flagged store full, one long receiver hold-off, %0d mismatches",
			full_pairs, mismatches);
		if (mismatches == 0 && pairs_expected.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
